// ===== rtl/mie_pkg.sv =====
// Shared types, result kind codes and address helpers for the minicomputer
// instruction executor. No dependencies.
package mie_pkg;

    typedef logic [15:0] t_word;
    typedef logic [3:0]  t_kind;

    localparam int unsigned MIE_MEM_WORDS = 32768;

    // Result kind codes
    localparam t_kind KIND_HALT = 4'd0;
    localparam t_kind KIND_MOV  = 4'd1;
    localparam t_kind KIND_CMP  = 4'd2;
    localparam t_kind KIND_ADD  = 4'd3;
    localparam t_kind KIND_SUB  = 4'd4;
    localparam t_kind KIND_SOB  = 4'd5;
    localparam t_kind KIND_BR   = 4'd6;
    localparam t_kind KIND_BNE  = 4'd7;
    localparam t_kind KIND_BEQ  = 4'd8;
    localparam t_kind KIND_ASR  = 4'd9;
    localparam t_kind KIND_ASL  = 4'd10;
    localparam t_kind KIND_NOP  = 4'd11;
    localparam t_kind KIND_LOAD = 4'd12;

    // Opcode fields
    localparam logic [3:0] OP_MOV = 4'd1;
    localparam logic [3:0] OP_CMP = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd6;
    localparam logic [3:0] OP_SUB = 4'd14;
    localparam logic [6:0] OP_SOB = 7'o77;
    localparam logic [9:0] OP_ASR = 10'o62;
    localparam logic [9:0] OP_ASL = 10'o63;
    localparam logic [7:0] OP_BR  = 8'd1;
    localparam logic [7:0] OP_BNE = 8'd2;
    localparam logic [7:0] OP_BEQ = 8'd3;

    // Item command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Word index reduced modulo the memory size; the six compare-subtract steps
    // finish it for any index below 64 times the size.
    function automatic logic [14:0] word_mod(input logic [14:0] x, input logic [20:0] m);
        logic [20:0] rr;
        rr = {6'd0, x};
        for (int k = 5; k >= 0; k--) begin
            if (rr >= (m << k)) begin
                rr = rr - (m << k);
            end
        end
        return rr[14:0];
    endfunction

endpackage

// ===== rtl/mie_if.sv =====
// Handshake channels of the executor: the command item and the result item.
// Uses mie_pkg.
interface mie_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [14:0] load_addr;
    logic [15:0] load_data;
    modport source (output valid, cmd, load_addr, load_data, input ready);
    modport sink   (input valid, cmd, load_addr, load_data, output ready);
endinterface

interface mie_out_if;
    import mie_pkg::*;
    logic        valid;
    logic        ready;
    logic        halted;
    t_word       pc_after;
    logic [3:0]  flags;
    t_kind       kind;
    logic        branch_taken;
    modport source (output valid, halted, pc_after, flags, kind, branch_taken, input ready);
    modport sink   (input valid, halted, pc_after, flags, kind, branch_taken, output ready);
endinterface

// ===== rtl/mie_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module mie_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/minicomputer_instruction_executor.sv =====
// Executes a PDP-11 style word subset (HALT MOV CMP ADD SUB SOB BR BNE BEQ ASR
// ASL) one instruction per step item, or writes one program word per load item.
// Uses mie_pkg, mie_if and mie_ram. The pace of an instruction is set by the
// single port of word memory: the fetch, every index word, pointer and operand
// read and the write-back use the port in turn, with registered read data.
// One item is in flight at a time; the next item enters only once the last
// result is taken, or in the cycle it is taken. Word memory has no reset.
module minicomputer_instruction_executor #(
    parameter int unsigned MEM_WORDS = mie_pkg::MIE_MEM_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mie_in_if.sink    i_in,
    mie_out_if.source o_out
);
    import mie_pkg::*;

    localparam int unsigned AW = $clog2(MEM_WORDS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_RES   = 4'd3;
    localparam logic [3:0] S_IND   = 4'd4;
    localparam logic [3:0] S_X6    = 4'd5;
    localparam logic [3:0] S_GET   = 4'd6;
    localparam logic [3:0] S_GETW  = 4'd7;
    localparam logic [3:0] S_EXE   = 4'd8;
    localparam logic [3:0] S_SOB   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state, n_state;
    t_word      r_gpr [8];
    logic [3:0] r_flags, n_flags;
    logic       r_halt, n_halt;
    t_word      r_ir, n_ir;
    logic       r_opsel, n_opsel;
    logic       r_inreg, n_inreg;
    t_word      r_addr, n_addr;
    t_word      r_sv, n_sv;
    t_word      r_dv, n_dv;
    t_word      r_tmp, n_tmp;
    t_kind      r_kind, n_kind;
    logic       r_taken, n_taken;

    logic       r_ovalid, n_ovalid;
    logic       r_ohalt, n_ohalt;
    t_word      r_opc, n_opc;
    logic [3:0] r_oflags, n_oflags;
    t_kind      r_okind, n_okind;
    logic       r_otaken, n_otaken;

    logic        rf_we;
    logic [2:0]  rf_widx;
    t_word       rf_wdata;
    logic [2:0]  w_ridx;
    t_word       w_rv;

    logic        ram_we;
    logic        ram_load;
    t_word       ram_baddr;
    t_word       ram_wdata;
    t_word       ram_rdata;
    logic [14:0] ram_widx;

    logic        w_accept;
    logic [2:0]  w_mode;
    logic [2:0]  w_r;
    logic        is_dbl, is_sob, is_br, is_sh;
    logic        br_take;
    t_word       br_off;
    t_word       sob_off;
    t_word       ix_sum;
    logic [16:0] sum17, cmp17, sub17;
    t_word       ex_res;
    logic        ex_c, ex_v;
    logic [3:0]  ex_flags;
    t_word       w_val;

    assign i_in.ready = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_mode = r_opsel ? r_ir[5:3] : r_ir[11:9];
    assign w_r    = r_opsel ? r_ir[2:0] : r_ir[8:6];

    assign is_dbl = (r_ir[15:12] == OP_MOV) || (r_ir[15:12] == OP_CMP) ||
                    (r_ir[15:12] == OP_ADD) || (r_ir[15:12] == OP_SUB);
    assign is_sob = (r_ir[15:9] == OP_SOB);
    assign is_br  = (r_ir[15:8] == OP_BR) || (r_ir[15:8] == OP_BNE) ||
                    (r_ir[15:8] == OP_BEQ);
    assign is_sh  = (r_ir[15:6] == OP_ASR) || (r_ir[15:6] == OP_ASL);
    assign br_take = (r_ir[15:8] == OP_BR) ||
                     ((r_ir[15:8] == OP_BNE) && !r_flags[2]) ||
                     ((r_ir[15:8] == OP_BEQ) && r_flags[2]);
    assign br_off  = {{7{r_ir[7]}}, r_ir[7:0], 1'b0};
    assign sob_off = {9'd0, r_ir[5:0], 1'b0};

    // shared register read port; the result step reads the PC directly
    always_comb begin
        w_ridx = w_r;
        case (r_state)
            S_IDLE, S_SOB: w_ridx = 3'd7;
            S_DEC:         w_ridx = is_sob ? r_ir[8:6] : 3'd7;
            S_RES:         w_ridx = (w_mode[2:1] == 2'b11) ? 3'd7 : w_r;
            default:       w_ridx = w_r;
        endcase
    end
    assign w_rv   = r_gpr[w_ridx];
    assign ix_sum = ram_rdata + w_rv;

    // ALU for the execute step
    assign sum17 = {1'b0, r_dv} + {1'b0, r_sv};
    assign cmp17 = {1'b0, r_sv} - {1'b0, r_dv};
    assign sub17 = {1'b0, r_dv} - {1'b0, r_sv};

    always_comb begin
        ex_res = r_sv;
        ex_c   = r_flags[0];
        ex_v   = 1'b0;
        case (r_kind)
            KIND_ADD: begin
                ex_res = sum17[15:0];
                ex_c   = sum17[16];
                ex_v   = !(r_sv[15] ^ r_dv[15]) && (r_sv[15] ^ sum17[15]);
            end
            KIND_CMP: begin
                ex_res = cmp17[15:0];
                ex_c   = cmp17[16];
                ex_v   = (r_sv[15] ^ r_dv[15]) && !(r_dv[15] ^ cmp17[15]);
            end
            KIND_SUB: begin
                ex_res = sub17[15:0];
                ex_c   = sub17[16];
                ex_v   = (r_sv[15] ^ r_dv[15]) && !(r_sv[15] ^ sub17[15]);
            end
            KIND_ASR: begin
                ex_res = {r_dv[15], r_dv[15:1]};
                ex_c   = r_dv[0];
                ex_v   = r_dv[15] ^ r_dv[0];
            end
            KIND_ASL: begin
                ex_res = {r_dv[14:0], 1'b0};
                ex_c   = r_dv[15];
                ex_v   = r_dv[14] ^ r_dv[15];
            end
            default: begin
                ex_res = r_sv;
                ex_c   = r_flags[0];
                ex_v   = 1'b0;
            end
        endcase
        ex_flags = {ex_res[15], (ex_res == 16'd0), ex_v, ex_c};
    end

    always_comb begin
        n_state  = r_state;
        n_flags  = r_flags;
        n_halt   = r_halt;
        n_ir     = r_ir;
        n_opsel  = r_opsel;
        n_inreg  = r_inreg;
        n_addr   = r_addr;
        n_sv     = r_sv;
        n_dv     = r_dv;
        n_tmp    = r_tmp;
        n_kind   = r_kind;
        n_taken  = r_taken;
        n_ovalid = r_ovalid;
        n_ohalt  = r_ohalt;
        n_opc    = r_opc;
        n_oflags = r_oflags;
        n_okind  = r_okind;
        n_otaken = r_otaken;
        rf_we    = 1'b0;
        rf_widx  = 3'd7;
        rf_wdata = w_rv;
        ram_we   = 1'b0;
        ram_load = 1'b0;
        ram_baddr = r_addr;
        ram_wdata = r_sv;
        w_val    = r_inreg ? w_rv : ram_rdata;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_taken = 1'b0;
                    if (i_in.cmd == CMD_LOAD) begin
                        ram_load  = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = i_in.load_data;
                        n_kind    = KIND_LOAD;
                        n_state   = S_OUT;
                    end else if (r_halt) begin
                        n_kind  = KIND_HALT;
                        n_state = S_OUT;
                    end else begin
                        ram_baddr = w_rv;
                        rf_we     = 1'b1;
                        rf_wdata  = w_rv + 16'd2;
                        n_state   = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_ir    = ram_rdata;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (r_ir == 16'd0) begin
                    n_halt  = 1'b1;
                    n_kind  = KIND_HALT;
                    n_state = S_OUT;
                end else if (is_dbl) begin
                    n_opsel = 1'b0;
                    case (r_ir[15:12])
                        OP_MOV:  n_kind = KIND_MOV;
                        OP_CMP:  n_kind = KIND_CMP;
                        OP_ADD:  n_kind = KIND_ADD;
                        default: n_kind = KIND_SUB;
                    endcase
                    n_state = S_RES;
                end else if (is_sob) begin
                    rf_we    = 1'b1;
                    rf_widx  = r_ir[8:6];
                    rf_wdata = w_rv - 16'd1;
                    n_tmp    = w_rv - 16'd1;
                    n_kind   = KIND_SOB;
                    n_state  = S_SOB;
                end else if (is_br) begin
                    case (r_ir[15:8])
                        OP_BR:   n_kind = KIND_BR;
                        OP_BNE:  n_kind = KIND_BNE;
                        default: n_kind = KIND_BEQ;
                    endcase
                    if (br_take) begin
                        rf_we    = 1'b1;
                        rf_wdata = w_rv + br_off;
                        n_taken  = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (is_sh) begin
                    n_opsel = 1'b1;
                    n_kind  = (r_ir[15:6] == OP_ASR) ? KIND_ASR : KIND_ASL;
                    n_state = S_RES;
                end else begin
                    n_kind  = KIND_NOP;
                    n_state = S_OUT;
                end
            end
            S_SOB: begin
                if (r_tmp != 16'd0) begin
                    rf_we    = 1'b1;
                    rf_wdata = w_rv - sob_off;
                    n_taken  = 1'b1;
                end
                n_state = S_OUT;
            end
            S_RES: begin
                n_inreg = 1'b0;
                rf_widx = w_r;
                case (w_mode)
                    3'd0: begin
                        n_inreg = 1'b1;
                        n_state = S_GET;
                    end
                    3'd1: begin
                        n_addr  = w_rv;
                        n_state = S_GET;
                    end
                    3'd2: begin
                        n_addr   = w_rv;
                        rf_we    = 1'b1;
                        rf_wdata = w_rv + 16'd2;
                        n_state  = S_GET;
                    end
                    3'd3: begin
                        rf_we     = 1'b1;
                        rf_wdata  = w_rv + 16'd2;
                        ram_baddr = w_rv;
                        n_state   = S_IND;
                    end
                    3'd4: begin
                        rf_we    = 1'b1;
                        rf_wdata = w_rv - 16'd2;
                        n_addr   = w_rv - 16'd2;
                        n_state  = S_GET;
                    end
                    3'd5: begin
                        rf_we     = 1'b1;
                        rf_wdata  = w_rv - 16'd2;
                        ram_baddr = w_rv - 16'd2;
                        n_state   = S_IND;
                    end
                    default: begin
                        // index word follows in the instruction stream
                        rf_widx   = 3'd7;
                        rf_we     = 1'b1;
                        rf_wdata  = w_rv + 16'd2;
                        ram_baddr = w_rv;
                        n_state   = S_X6;
                    end
                endcase
            end
            S_IND: begin
                n_addr  = ram_rdata;
                n_state = S_GET;
            end
            S_X6: begin
                if (w_mode == 3'd7) begin
                    ram_baddr = ix_sum;
                    n_state   = S_IND;
                end else begin
                    n_addr  = ix_sum;
                    n_state = S_GET;
                end
            end
            S_GET: begin
                if (r_opsel && (r_kind == KIND_MOV)) begin
                    n_state = S_EXE;
                end else if (r_inreg) begin
                    if (!r_opsel) begin
                        n_sv    = w_val;
                        n_opsel = 1'b1;
                        n_state = S_RES;
                    end else begin
                        n_dv    = w_val;
                        n_state = S_EXE;
                    end
                end else begin
                    ram_baddr = r_addr;
                    n_state   = S_GETW;
                end
            end
            S_GETW: begin
                if (!r_opsel) begin
                    n_sv    = w_val;
                    n_opsel = 1'b1;
                    n_state = S_RES;
                end else begin
                    n_dv    = w_val;
                    n_state = S_EXE;
                end
            end
            S_EXE: begin
                if (r_kind == KIND_MOV) begin
                    n_flags = {ex_res[15], (ex_res == 16'd0), 1'b0, r_flags[0]};
                end else begin
                    n_flags = ex_flags;
                end
                if (r_kind != KIND_CMP) begin
                    if (r_inreg) begin
                        rf_we    = 1'b1;
                        rf_widx  = r_ir[2:0];
                        rf_wdata = ex_res;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = ex_res;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_ohalt  = r_halt;
                n_opc    = r_gpr[7];
                n_oflags = r_flags;
                n_okind  = r_kind;
                n_otaken = r_taken;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ram_widx = ram_load ? word_mod(i_in.load_addr, 21'(MEM_WORDS))
                               : word_mod(ram_baddr[15:1], 21'(MEM_WORDS));

    mie_ram #(
        .WIDTH(16),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_widx[AW-1:0]),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flags  <= 4'd0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_gpr[i] <= 16'd0;
            end
        end else begin
            r_state  <= n_state;
            r_flags  <= n_flags;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
            if (rf_we) begin
                r_gpr[rf_widx] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir     <= n_ir;
        r_opsel  <= n_opsel;
        r_inreg  <= n_inreg;
        r_addr   <= n_addr;
        r_sv     <= n_sv;
        r_dv     <= n_dv;
        r_tmp    <= n_tmp;
        r_kind   <= n_kind;
        r_taken  <= n_taken;
        r_ohalt  <= n_ohalt;
        r_opc    <= n_opc;
        r_oflags <= n_oflags;
        r_okind  <= n_okind;
        r_otaken <= n_otaken;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.halted       = r_ohalt;
    assign o_out.pc_after     = r_opc;
    assign o_out.flags        = r_oflags;
    assign o_out.kind         = r_okind;
    assign o_out.branch_taken = r_otaken;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halted bit cleared without reset");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside the result step");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!r_ovalid || o_out.ready))
        else $error("item accepted while a result is stuck");

    a_mem_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE || r_state == S_EXE))
        else $error("memory written outside load or write-back");

endmodule
